// ----- rtl/y2b_pkg.sv -----
// shared types, constants and functions for the yuv422 to bmp24 encoder
`timescale 1ns / 1ps
`default_nettype none
package y2b_pkg;

  localparam int ADDR_W = 26;
  localparam int DIM_W = 13;
  localparam int STRIDE_W = 15;
  localparam int HDR_LEN = 54;
  localparam int INFO_LEN = 40;
  localparam int BPP = 24;
  localparam int CHROMA_MID = 128;

  // register indexes
  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  // what one item turns into at the output
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_HDR = 2'd1;
  localparam logic [1:0] KIND_PIX = 2'd2;
  localparam logic [1:0] KIND_REFUSE = 2'd3;

  // q16 conversion coefficients
  localparam logic signed [27:0] K_R_CR = 28'sd91881;
  localparam logic signed [27:0] K_G_CB = 28'sd22554;
  localparam logic signed [27:0] K_G_CR = 28'sd46802;
  localparam logic signed [27:0] K_B_CB = 28'sd116130;

  typedef struct packed {
    logic [ADDR_W-1:0] len;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [ADDR_W-1:0] rgb;
  } geom_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] len;
    logic [7:0]        b;
    logic [7:0]        g;
    logic [7:0]        r;
  } load_t;

  function automatic logic [7:0] clamp_q16(input logic signed [27:0] v);
    logic [7:0] res;
    if (v[27]) begin
      res = 8'd0;
    end else if (|v[26:24]) begin
      res = 8'hFF;
    end else begin
      res = v[23:16];
    end
    return res;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input geom_t g);
    logic [31:0] len32;
    logic [31:0] w32;
    logic [31:0] h32;
    logic [31:0] rgb32;
    logic [7:0]  v;
    len32 = 32'(g.len);
    w32 = 32'(g.w);
    h32 = 32'(g.h);
    rgb32 = 32'(g.rgb);
    case (idx)
      6'd0:  v = 8'h42;
      6'd1:  v = 8'h4D;
      6'd2:  v = len32[7:0];
      6'd3:  v = len32[15:8];
      6'd4:  v = len32[23:16];
      6'd5:  v = len32[31:24];
      6'd10: v = 8'(HDR_LEN);
      6'd14: v = 8'(INFO_LEN);
      6'd18: v = w32[7:0];
      6'd19: v = w32[15:8];
      6'd20: v = w32[23:16];
      6'd21: v = w32[31:24];
      6'd22: v = h32[7:0];
      6'd23: v = h32[15:8];
      6'd24: v = h32[23:16];
      6'd25: v = h32[31:24];
      6'd26: v = 8'd1;
      6'd28: v = 8'(BPP);
      6'd34: v = rgb32[7:0];
      6'd35: v = rgb32[15:8];
      6'd36: v = rgb32[23:16];
      6'd37: v = rgb32[31:24];
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/y2b_color.sv -----
// ycbcr to rgb conversion, q16 fixed point with clamping
`timescale 1ns / 1ps
`default_nettype none
module y2b_color (
  input  wire logic [7:0] luma,
  input  wire logic [7:0] chroma_blue,
  input  wire logic [7:0] chroma_red,
  output logic [7:0]      blue,
  output logic [7:0]      green,
  output logic [7:0]      red
);

  logic signed [8:0]  dcb;
  logic signed [8:0]  dcr;
  logic signed [27:0] dcb_w;
  logic signed [27:0] dcr_w;
  logic signed [27:0] ys;
  logic signed [27:0] r_sum;
  logic signed [27:0] g_sum;
  logic signed [27:0] b_sum;

  assign dcb = $signed({1'b0, chroma_blue}) - 9'(y2b_pkg::CHROMA_MID);
  assign dcr = $signed({1'b0, chroma_red}) - 9'(y2b_pkg::CHROMA_MID);
  assign dcb_w = 28'(dcb);
  assign dcr_w = 28'(dcr);
  assign ys = $signed({4'b0, luma, 16'b0});

  assign r_sum = ys + dcr_w * y2b_pkg::K_R_CR;
  assign g_sum = ys - dcb_w * y2b_pkg::K_G_CB - dcr_w * y2b_pkg::K_G_CR;
  assign b_sum = ys + dcb_w * y2b_pkg::K_B_CB;

  assign red = y2b_pkg::clamp_q16(r_sum);
  assign green = y2b_pkg::clamp_q16(g_sum);
  assign blue = y2b_pkg::clamp_q16(b_sum);

endmodule
`default_nettype wire

// ----- rtl/y2b_frame.sv -----
// frame geometry check, raster position and pixel address
`timescale 1ns / 1ps
`default_nettype none
module y2b_frame #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       take,
  input  wire logic                       action,
  input  wire logic [y2b_pkg::DIM_W-1:0]  image_width,
  input  wire logic [y2b_pkg::DIM_W-1:0]  image_height,
  input  wire logic [y2b_pkg::ADDR_W-1:0] dest_capacity,
  input  wire logic [7:0]                 blue,
  input  wire logic [7:0]                 green,
  input  wire logic [7:0]                 red,
  output y2b_pkg::load_t                  ld,
  output y2b_pkg::geom_t                  geom
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic                            active;
  logic [CW-1:0]                   col;
  logic [RW-1:0]                   row;
  logic [y2b_pkg::STRIDE_W-1:0]    stride;

  logic [18:0]                     w24;
  logic [13:0]                     words;
  logic [y2b_pkg::STRIDE_W-1:0]    new_stride;
  logic [27:0]                     new_rgb;
  logic [28:0]                     new_len;
  logic                            bad;
  logic [15:0]                     rows_left;
  logic [27:0]                     row_off;
  logic [27:0]                     pix_addr;
  logic                            col_wrap;
  logic                            row_wrap;

  // stride is the row length rounded up to a whole word
  assign w24 = 19'(image_width) * 19'd24;
  assign words = 14'((w24 + 19'd31) >> 5);
  assign new_stride = {words[12:0], 2'b00};
  assign new_rgb = 28'(new_stride) * 28'(image_height);
  assign new_len = 29'(y2b_pkg::HDR_LEN) + 29'(new_rgb);
  assign bad = (image_width == '0) || (image_height == '0) ||
               (32'(image_width) > 32'(MAX_WIDTH)) ||
               (32'(image_height) > 32'(MAX_HEIGHT)) ||
               (new_len > 29'(dest_capacity));

  // bottom-up row order
  assign rows_left = 16'(geom.h) - 16'd1 - 16'(row);
  assign row_off = 28'(rows_left) * 28'(stride);
  assign pix_addr = 28'(y2b_pkg::HDR_LEN) + row_off + 28'(col) * 28'd3;

  assign col_wrap = (16'(col) + 16'd1) >= 16'(geom.w);
  assign row_wrap = (16'(row) + 16'd1) >= 16'(geom.h);

  always_comb begin
    ld.b = blue;
    ld.g = green;
    ld.r = red;
    ld.addr = 26'(pix_addr);
    ld.len = geom.len;
    if (!action) begin
      ld.addr = '0;
      if (bad) begin
        ld.kind = y2b_pkg::KIND_REFUSE;
        ld.len = '0;
      end else begin
        ld.kind = y2b_pkg::KIND_HDR;
        ld.len = 26'(new_len);
      end
    end else if (active) begin
      ld.kind = y2b_pkg::KIND_PIX;
    end else begin
      ld.kind = y2b_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      col <= '0;
      row <= '0;
      stride <= '0;
      geom <= '0;
    end else if (take) begin
      if (!action) begin
        active <= !bad;
        col <= '0;
        row <= '0;
        if (!bad) begin
          stride <= new_stride;
          geom.len <= 26'(new_len);
          geom.w <= image_width;
          geom.h <= image_height;
          geom.rgb <= 26'(new_rgb);
        end
      end else if (active) begin
        if (col_wrap) begin
          col <= '0;
          if (row_wrap) begin
            row <= '0;
            active <= 1'b0;
          end else begin
            row <= row + 1'b1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/y2b_emit.sv -----
// output register that sends the bytes of one item in order
`timescale 1ns / 1ps
`default_nettype none
module y2b_emit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       take,
  input  wire y2b_pkg::load_t             ld,
  input  wire y2b_pkg::geom_t             geom,
  output logic                            free,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [y2b_pkg::ADDR_W-1:0]      byte_addr,
  output logic [7:0]                      byte_value,
  output logic                            refused,
  output logic [y2b_pkg::ADDR_W-1:0]      file_length,
  output logic                            last
);

  logic                        is_hdr;
  logic [5:0]                  remain;
  logic [7:0]                  hold_g;
  logic [7:0]                  hold_r;
  logic [y2b_pkg::ADDR_W-1:0]  addr_inc;

  assign free = !out_valid || (out_ready && last);
  assign addr_inc = byte_addr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last <= 1'b0;
      remain <= '0;
    end else if (take) begin
      byte_addr <= ld.addr;
      file_length <= ld.len;
      hold_g <= ld.g;
      hold_r <= ld.r;
      case (ld.kind)
        y2b_pkg::KIND_HDR: begin
          out_valid <= 1'b1;
          is_hdr <= 1'b1;
          byte_value <= y2b_pkg::hdr_byte(6'd0, geom);
          refused <= 1'b0;
          remain <= 6'(y2b_pkg::HDR_LEN - 1);
          last <= 1'b0;
        end
        y2b_pkg::KIND_PIX: begin
          out_valid <= 1'b1;
          is_hdr <= 1'b0;
          byte_value <= ld.b;
          refused <= 1'b0;
          remain <= 6'd2;
          last <= 1'b0;
        end
        y2b_pkg::KIND_REFUSE: begin
          out_valid <= 1'b1;
          is_hdr <= 1'b0;
          byte_value <= 8'd0;
          refused <= 1'b1;
          remain <= 6'd0;
          last <= 1'b1;
        end
        default: begin
          out_valid <= 1'b0;
          last <= 1'b0;
        end
      endcase
    end else if (out_valid && out_ready) begin
      if (last) begin
        out_valid <= 1'b0;
        last <= 1'b0;
      end else begin
        byte_addr <= addr_inc;
        remain <= remain - 1'b1;
        last <= (remain == 6'd1);
        if (is_hdr) begin
          byte_value <= y2b_pkg::hdr_byte(addr_inc[5:0], geom);
        end else begin
          byte_value <= hold_g;
          hold_g <= hold_r;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/yuv422_to_bmp24_encoder.sv -----
// top level: 4:2:2 ycbcr items to a bottom-up 24-bit bmp byte stream
// input channel (in_valid/in_ready): action 0 starts a frame, action 1 is one
//   pixel (luma plus its shared chroma pair) in raster order
// output channel (out_valid/out_ready): one file byte per transfer, with its
//   address, the file length, a refused flag and last on the final byte
// config port: cfg_we with cfg_index 0 width, 1 height, 2 buffer capacity;
//   values are sampled at the next frame start
// an accepted item waits in the input register and moves into the output
//   register when that one is free; its first byte is then on the output
// a pixel gives 3 bytes, one byte per cycle on the output register while
//   out_ready is high; a frame start gives the 54 header bytes, or 1 byte
//   when refused; a pixel outside a frame gives no bytes
// an input register holds the next item while the output register drains,
//   so the next item enters as the last byte of the current one is taken
// a stalled receiver holds the current byte; the input register fills and
//   then in_ready drops
// reset clears both registers, the frame position and the config to
//   width 1, height 1, capacity 0; no frame is open after reset
`timescale 1ns / 1ps
`default_nettype none
module yuv422_to_bmp24_encoder #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       action,
  input  wire logic [7:0]                 luma,
  input  wire logic [7:0]                 chroma_blue,
  input  wire logic [7:0]                 chroma_red,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [y2b_pkg::ADDR_W-1:0]      byte_addr,
  output logic [7:0]                      byte_value,
  output logic                            refused,
  output logic [y2b_pkg::ADDR_W-1:0]      file_length,
  output logic                            last,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [y2b_pkg::ADDR_W-1:0] cfg_data
);

  logic                        s1_valid;
  logic                        s1_action;
  logic [7:0]                  s1_luma;
  logic [7:0]                  s1_cb;
  logic [7:0]                  s1_cr;
  logic                        take;
  logic                        free;
  logic [y2b_pkg::DIM_W-1:0]   image_width;
  logic [y2b_pkg::DIM_W-1:0]   image_height;
  logic [y2b_pkg::ADDR_W-1:0]  dest_capacity;
  logic [7:0]                  blue;
  logic [7:0]                  green;
  logic [7:0]                  red;
  y2b_pkg::load_t              ld;
  y2b_pkg::geom_t              geom;

  assign take = s1_valid && free;
  assign in_ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd1;
      image_height <= 13'd1;
      dest_capacity <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        y2b_pkg::REG_WIDTH:    image_width <= cfg_data[y2b_pkg::DIM_W-1:0];
        y2b_pkg::REG_HEIGHT:   image_height <= cfg_data[y2b_pkg::DIM_W-1:0];
        y2b_pkg::REG_CAPACITY: dest_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_luma <= luma;
      s1_cb <= chroma_blue;
      s1_cr <= chroma_red;
    end
  end

  y2b_color u_color (
    .luma        (s1_luma),
    .chroma_blue (s1_cb),
    .chroma_red  (s1_cr),
    .blue        (blue),
    .green       (green),
    .red         (red)
  );

  y2b_frame #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_frame (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .action        (s1_action),
    .image_width   (image_width),
    .image_height  (image_height),
    .dest_capacity (dest_capacity),
    .blue          (blue),
    .green         (green),
    .red           (red),
    .ld            (ld),
    .geom          (geom)
  );

  y2b_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .ld          (ld),
    .geom        (geom),
    .free        (free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_addr   (byte_addr),
    .byte_value  (byte_value),
    .refused     (refused),
    .file_length (file_length),
    .last        (last)
  );

endmodule
`default_nettype wire

// ----- rtl/y2b_checker.sv -----
// port-level checks for the encoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module y2b_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [y2b_pkg::ADDR_W-1:0] byte_addr,
  input wire logic [7:0]                 byte_value,
  input wire logic                       refused,
  input wire logic [y2b_pkg::ADDR_W-1:0] file_length,
  input wire logic                       last
);

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_addr) && $stable(byte_value))
    else $error("output item changed while stalled");

  // a refused frame is one lone item
  a_refuse: assert property (@(posedge clk) disable iff (rst)
    out_valid && refused |-> last && byte_addr == '0 && file_length == '0 &&
                             byte_value == 8'd0)
    else $error("bad refused item");

  // bytes of one item follow at consecutive addresses with no gap
  a_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && byte_addr == $past(byte_addr) + 1'b1 &&
      file_length == $past(file_length))
    else $error("byte sequence broken");

  // every byte lies inside the file
  a_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && !refused |-> byte_addr < file_length)
    else $error("byte address beyond file length");

endmodule

bind yuv422_to_bmp24_encoder y2b_checker u_chk (.*);
`default_nettype wire
